// ===== rtl/fta_pkg.sv =====
// Shared types, widths, codes and reset values for the fixed-timestep accumulator.
// Used by every module of the block; depends on nothing.
package fta_pkg;

    // Field and register widths.
    localparam int TS_W        = 16;   // Q8.8 time scale
    localparam int FS_W        = 20;   // fixed step length
    localparam int IV_W        = 24;   // window intervals
    localparam int DT_W        = 20;   // frame duration and step cost
    localparam int SCALE_FRAC  = 8;    // fraction bits of the time scale
    localparam int PROD_W      = DT_W + TS_W;
    localparam int SD_W        = PROD_W - SCALE_FRAC;
    localparam int TOT_W       = 56;   // scaled and fixed totals
    localparam int UNS_OUT_W   = 48;   // reported unscaled time
    localparam int CNT_W       = 32;   // frame and step counters, rates
    localparam int AVG_W       = 20;   // average step cost

    // Rate numerator: 1e6 us per second times 256 for the Q24.8 result.
    localparam int              RATE_W   = 28;
    localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;

    // Shared divider: dividend is sized for count * RATE_NUM, one quotient bit per cycle.
    localparam int DVD_W     = CNT_W + RATE_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHY_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS_ENABLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PHY_ENABLE   = 3'd5;

    localparam logic [TS_W-1:0] TIME_SCALE_RST   = 16'd256;
    localparam logic [FS_W-1:0] FIXED_STEP_RST   = 20'd20000;
    localparam logic [IV_W-1:0] FPS_INTERVAL_RST = 24'd500000;
    localparam logic [IV_W-1:0] PHY_INTERVAL_RST = 24'd1000000;

    // Stream widths.
    localparam int S_TDATA_W = 2 * DT_W;
    localparam int M_FIELD_W = 1 + SD_W + UNS_OUT_W + 2 * TOT_W + 2 * CNT_W + AVG_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Request kinds.
    typedef logic [1:0] req_type_t;
    localparam req_type_t REQ_FRAME = 2'd0;
    localparam req_type_t REQ_STEP  = 2'd1;
    localparam req_type_t REQ_COST  = 2'd2;

    // Division jobs.
    typedef logic [1:0] div_sel_t;
    localparam div_sel_t DSEL_FPS = 2'd0;
    localparam div_sel_t DSEL_PHY = 2'd1;
    localparam div_sel_t DSEL_AVG = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      exec;
        logic      frame;
        logic      step;
        logic      div_start;
        div_sel_t  div_sel;
        logic      wb;
        div_sel_t  wb_sel;
        logic      out_load;
    } fta_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_type_t req_type;
        logic      fps_close;
        logic      phys_close;
        logic      div_done;
    } fta_status_t;

endpackage

// ===== rtl/fta_divider.sv =====
// Restoring radix-2 divider shared by the rate and average computations.
// Depends on fta_pkg for the dividend width and step count.
module fta_divider #(
    parameter int DVS_W = 48
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [fta_pkg::DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]         divisor,
    output logic                     done,
    output logic [fta_pkg::DVD_W-1:0] quotient
);

    logic [DVS_W-1:0]              rem_reg, rem_next;
    logic [fta_pkg::DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]              dvs_reg, dvs_next;
    logic [fta_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           fits;

    assign shifted = {rem_reg, quo_reg[fta_pkg::DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_next = {quo_reg[fta_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fta_pkg::DIV_CNT_W'(fta_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/fta_datapath.sv =====
// Datapath of the fixed-timestep accumulator: configuration, totals, windows,
// the scale multiplier, the shared divider and the result register.
// Depends on fta_pkg and fta_divider.
module fta_datapath #(
    parameter int AW = 48
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [fta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fta_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  fta_pkg::req_type_t               in_req_type,
    input  logic [fta_pkg::S_TDATA_W-1:0]    in_data,
    input  fta_pkg::fta_cmd_t                cmd,
    output fta_pkg::fta_status_t             status,
    output logic [fta_pkg::M_TDATA_W-1:0]    out_data
);

    localparam int DT_W  = fta_pkg::DT_W;
    localparam int TOT_W = fta_pkg::TOT_W;
    localparam int CNT_W = fta_pkg::CNT_W;
    localparam int DVD_W = fta_pkg::DVD_W;

    // Configuration.
    logic [fta_pkg::TS_W-1:0] time_scale_reg, time_scale_next;
    logic [fta_pkg::FS_W-1:0] fixed_step_reg, fixed_step_next;
    logic [fta_pkg::IV_W-1:0] fps_iv_reg, fps_iv_next;
    logic [fta_pkg::IV_W-1:0] phy_iv_reg, phy_iv_next;
    logic                     fps_en_reg, fps_en_next;
    logic                     phy_en_reg, phy_en_next;

    // Captured request.
    fta_pkg::req_type_t req_type_reg, req_type_next;
    logic [DT_W-1:0]    dt_reg, dt_next;
    logic [DT_W-1:0]    cost_in_reg, cost_in_next;

    // State.
    logic [fta_pkg::SD_W-1:0]  prod_reg, prod_next;
    logic                      taken_reg, taken_next;
    logic [fta_pkg::SD_W-1:0]  last_sd_reg, last_sd_next;
    logic [AW-1:0]             unscaled_reg, unscaled_next;
    logic [TOT_W-1:0]          scaled_reg, scaled_next;
    logic [AW-1:0]             reserve_reg, reserve_next;
    logic [TOT_W-1:0]          fixed_reg, fixed_next;
    logic [CNT_W-1:0]          frame_cnt_reg, frame_cnt_next;
    logic [AW-1:0]             fps_win_reg, fps_win_next;
    logic [CNT_W-1:0]          fps_res_reg, fps_res_next;
    logic [CNT_W-1:0]          step_cnt_reg, step_cnt_next;
    logic [AW-1:0]             phy_win_reg, phy_win_next;
    logic [AW-1:0]             cost_sum_reg, cost_sum_next;
    logic [CNT_W-1:0]          phy_res_reg, phy_res_next;
    logic [fta_pkg::AVG_W-1:0] avg_res_reg, avg_res_next;
    logic                      dvs_zero_reg, dvs_zero_next;
    logic [fta_pkg::M_TDATA_W-1:0] out_reg, out_next;

    // Scale multiplier, shared by frame durations and the fixed step.
    logic [DT_W-1:0]            mul_a;
    logic [fta_pkg::PROD_W-1:0] mul_p;

    assign mul_a = (req_type_reg == fta_pkg::REQ_STEP) ? fixed_step_reg : dt_reg;
    assign mul_p = fta_pkg::PROD_W'(mul_a) * fta_pkg::PROD_W'(time_scale_reg);

    // Saturating adders.
    logic [AW:0]      unscaled_sum, reserve_sum, fps_win_sum, phy_win_sum, cost_sum_sum;
    logic [TOT_W:0]   scaled_sum, fixed_sum;
    logic [AW-1:0]    unscaled_sat, reserve_sat, fps_win_sat, phy_win_sat, cost_sum_sat;
    logic [TOT_W-1:0] scaled_sat, fixed_sat;
    logic [CNT_W-1:0] frame_inc, step_inc;

    assign unscaled_sum = {1'b0, unscaled_reg} + (AW+1)'(dt_reg);
    assign reserve_sum  = {1'b0, reserve_reg} + (AW+1)'(dt_reg);
    assign fps_win_sum  = {1'b0, fps_win_reg} + (AW+1)'(dt_reg);
    assign phy_win_sum  = {1'b0, phy_win_reg} + (AW+1)'(dt_reg);
    assign cost_sum_sum = {1'b0, cost_sum_reg} + (AW+1)'(cost_in_reg);
    assign scaled_sum   = {1'b0, scaled_reg} + (TOT_W+1)'(prod_reg);
    assign fixed_sum    = {1'b0, fixed_reg} + (TOT_W+1)'(prod_reg);

    assign unscaled_sat = unscaled_sum[AW] ? '1 : unscaled_sum[AW-1:0];
    assign reserve_sat  = reserve_sum[AW] ? '1 : reserve_sum[AW-1:0];
    assign fps_win_sat  = fps_win_sum[AW] ? '1 : fps_win_sum[AW-1:0];
    assign phy_win_sat  = phy_win_sum[AW] ? '1 : phy_win_sum[AW-1:0];
    assign cost_sum_sat = cost_sum_sum[AW] ? '1 : cost_sum_sum[AW-1:0];
    assign scaled_sat   = scaled_sum[TOT_W] ? '1 : scaled_sum[TOT_W-1:0];
    assign fixed_sat    = fixed_sum[TOT_W] ? '1 : fixed_sum[TOT_W-1:0];
    assign frame_inc    = (&frame_cnt_reg) ? frame_cnt_reg : frame_cnt_reg + 1'b1;
    assign step_inc     = (&step_cnt_reg) ? step_cnt_reg : step_cnt_reg + 1'b1;

    logic step_ok;
    assign step_ok = reserve_reg >= AW'(fixed_step_reg);

    // Division operands for the job being started.
    logic [CNT_W-1:0] rate_cnt;
    logic [DVD_W-1:0] rate_prod;
    logic [DVD_W-1:0] div_dividend;
    logic [AW-1:0]    div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    assign rate_cnt  = (cmd.div_sel == fta_pkg::DSEL_FPS) ? frame_cnt_reg : step_cnt_reg;
    assign rate_prod = DVD_W'(rate_cnt) * DVD_W'(fta_pkg::RATE_NUM);

    always_comb begin
        case (cmd.div_sel)
            fta_pkg::DSEL_FPS: begin
                div_dividend = rate_prod;
                div_divisor  = fps_win_reg;
            end
            fta_pkg::DSEL_PHY: begin
                div_dividend = rate_prod;
                div_divisor  = phy_win_reg;
            end
            default: begin
                div_dividend = DVD_W'(cost_sum_reg);
                div_divisor  = AW'(step_cnt_reg);
            end
        endcase
    end

    fta_divider #(
        .DVS_W (AW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // A zero divisor (empty window or no steps) reports zero.
    logic [CNT_W-1:0]          rate_sat;
    logic [fta_pkg::AVG_W-1:0] avg_sat;

    assign rate_sat = dvs_zero_reg ? '0 :
                      ((|div_quo[DVD_W-1:CNT_W]) ? '1 : div_quo[CNT_W-1:0]);
    assign avg_sat  = dvs_zero_reg ? '0 :
                      ((|div_quo[DVD_W-1:fta_pkg::AVG_W]) ? '1
                                                          : div_quo[fta_pkg::AVG_W-1:0]);

    // Reported unscaled time, capped at 48 bits when the accumulator is wider.
    logic [fta_pkg::UNS_OUT_W-1:0] unscaled_out;

    generate
        if (AW > fta_pkg::UNS_OUT_W) begin : g_uns_cap
            assign unscaled_out = (|unscaled_reg[AW-1:fta_pkg::UNS_OUT_W]) ? '1
                                  : unscaled_reg[fta_pkg::UNS_OUT_W-1:0];
        end else begin : g_uns_ext
            assign unscaled_out = fta_pkg::UNS_OUT_W'(unscaled_reg);
        end
    endgenerate

    always_comb begin
        time_scale_next = time_scale_reg;
        fixed_step_next = fixed_step_reg;
        fps_iv_next     = fps_iv_reg;
        phy_iv_next     = phy_iv_reg;
        fps_en_next     = fps_en_reg;
        phy_en_next     = phy_en_reg;
        req_type_next   = req_type_reg;
        dt_next         = dt_reg;
        cost_in_next    = cost_in_reg;
        prod_next       = prod_reg;
        taken_next      = taken_reg;
        last_sd_next    = last_sd_reg;
        unscaled_next   = unscaled_reg;
        scaled_next     = scaled_reg;
        reserve_next    = reserve_reg;
        fixed_next      = fixed_reg;
        frame_cnt_next  = frame_cnt_reg;
        fps_win_next    = fps_win_reg;
        fps_res_next    = fps_res_reg;
        step_cnt_next   = step_cnt_reg;
        phy_win_next    = phy_win_reg;
        cost_sum_next   = cost_sum_reg;
        phy_res_next    = phy_res_reg;
        avg_res_next    = avg_res_reg;
        dvs_zero_next   = dvs_zero_reg;
        out_next        = out_reg;

        if (cfg_we) begin
            case (cfg_index)
                fta_pkg::CFG_TIME_SCALE:   time_scale_next = cfg_wdata[fta_pkg::TS_W-1:0];
                fta_pkg::CFG_FIXED_STEP:   fixed_step_next = cfg_wdata[fta_pkg::FS_W-1:0];
                fta_pkg::CFG_FPS_INTERVAL: fps_iv_next = cfg_wdata[fta_pkg::IV_W-1:0];
                fta_pkg::CFG_PHY_INTERVAL: phy_iv_next = cfg_wdata[fta_pkg::IV_W-1:0];
                fta_pkg::CFG_FPS_ENABLE: begin
                    fps_en_next = cfg_wdata[0];
                    if (cfg_wdata[0]) begin
                        frame_cnt_next = '0;
                        fps_win_next   = '0;
                        fps_res_next   = '0;
                    end
                end
                fta_pkg::CFG_PHY_ENABLE: begin
                    phy_en_next = cfg_wdata[0];
                    if (cfg_wdata[0]) begin
                        step_cnt_next = '0;
                        phy_win_next  = '0;
                        cost_sum_next = '0;
                        phy_res_next  = '0;
                        avg_res_next  = '0;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.capture) begin
            req_type_next = in_req_type;
            dt_next       = in_data[DT_W-1:0];
            cost_in_next  = in_data[2*DT_W-1:DT_W];
        end

        if (cmd.exec) begin
            prod_next  = mul_p[fta_pkg::PROD_W-1:fta_pkg::SCALE_FRAC];
            taken_next = 1'b0;
            case (req_type_reg)
                fta_pkg::REQ_FRAME: begin
                    unscaled_next = unscaled_sat;
                    reserve_next  = reserve_sat;
                    if (fps_en_reg) begin
                        frame_cnt_next = frame_inc;
                        fps_win_next   = fps_win_sat;
                    end
                    if (phy_en_reg) begin
                        phy_win_next = phy_win_sat;
                    end
                end
                fta_pkg::REQ_STEP: begin
                    if (step_ok) begin
                        taken_next   = 1'b1;
                        reserve_next = reserve_reg - AW'(fixed_step_reg);
                        if (phy_en_reg) begin
                            step_cnt_next = step_inc;
                        end
                    end
                end
                fta_pkg::REQ_COST: begin
                    if (phy_en_reg) begin
                        cost_sum_next = cost_sum_sat;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.frame) begin
            last_sd_next = prod_reg;
            scaled_next  = scaled_sat;
        end

        if (cmd.step && taken_reg) begin
            fixed_next = fixed_sat;
        end

        if (cmd.div_start) begin
            dvs_zero_next = ~|div_divisor;
        end

        if (cmd.wb) begin
            case (cmd.wb_sel)
                fta_pkg::DSEL_FPS: begin
                    fps_res_next   = rate_sat;
                    frame_cnt_next = '0;
                    fps_win_next   = '0;
                end
                fta_pkg::DSEL_PHY: begin
                    phy_res_next = rate_sat;
                end
                default: begin
                    avg_res_next  = avg_sat;
                    step_cnt_next = '0;
                    phy_win_next  = '0;
                    cost_sum_next = '0;
                end
            endcase
        end

        if (cmd.out_load) begin
            out_next = fta_pkg::M_TDATA_W'({avg_res_reg, phy_res_reg, fps_res_reg,
                                            fixed_reg, scaled_reg, unscaled_out,
                                            last_sd_reg, taken_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_scale_reg <= fta_pkg::TIME_SCALE_RST;
            fixed_step_reg <= fta_pkg::FIXED_STEP_RST;
            fps_iv_reg     <= fta_pkg::FPS_INTERVAL_RST;
            phy_iv_reg     <= fta_pkg::PHY_INTERVAL_RST;
            fps_en_reg     <= 1'b0;
            phy_en_reg     <= 1'b0;
            taken_reg      <= 1'b0;
            last_sd_reg    <= '0;
            unscaled_reg   <= '0;
            scaled_reg     <= '0;
            reserve_reg    <= '0;
            fixed_reg      <= '0;
            frame_cnt_reg  <= '0;
            fps_win_reg    <= '0;
            fps_res_reg    <= '0;
            step_cnt_reg   <= '0;
            phy_win_reg    <= '0;
            cost_sum_reg   <= '0;
            phy_res_reg    <= '0;
            avg_res_reg    <= '0;
        end else begin
            time_scale_reg <= time_scale_next;
            fixed_step_reg <= fixed_step_next;
            fps_iv_reg     <= fps_iv_next;
            phy_iv_reg     <= phy_iv_next;
            fps_en_reg     <= fps_en_next;
            phy_en_reg     <= phy_en_next;
            taken_reg      <= taken_next;
            last_sd_reg    <= last_sd_next;
            unscaled_reg   <= unscaled_next;
            scaled_reg     <= scaled_next;
            reserve_reg    <= reserve_next;
            fixed_reg      <= fixed_next;
            frame_cnt_reg  <= frame_cnt_next;
            fps_win_reg    <= fps_win_next;
            fps_res_reg    <= fps_res_next;
            step_cnt_reg   <= step_cnt_next;
            phy_win_reg    <= phy_win_next;
            cost_sum_reg   <= cost_sum_next;
            phy_res_reg    <= phy_res_next;
            avg_res_reg    <= avg_res_next;
        end
        req_type_reg <= req_type_next;
        dt_reg       <= dt_next;
        cost_in_reg  <= cost_in_next;
        prod_reg     <= prod_next;
        dvs_zero_reg <= dvs_zero_next;
        out_reg      <= out_next;
    end

    assign status.req_type   = req_type_reg;
    assign status.fps_close  = fps_en_reg && (fps_win_reg >= AW'(fps_iv_reg));
    assign status.phys_close = phy_en_reg && (phy_win_reg >= AW'(phy_iv_reg));
    assign status.div_done   = div_done;
    assign out_data          = out_reg;

endmodule

// ===== rtl/fta_ctrl.sv =====
// Controller of the fixed-timestep accumulator: sequences one request through
// update, window closure divisions and the result register. Depends on fta_pkg.
module fta_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  fta_pkg::fta_status_t status,
    output fta_pkg::fta_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EXEC    = 4'd1;
    localparam logic [3:0] ST_FRAME   = 4'd2;
    localparam logic [3:0] ST_STEP    = 4'd3;
    localparam logic [3:0] ST_FPS_DIV = 4'd4;
    localparam logic [3:0] ST_PHY_DIV = 4'd5;
    localparam logic [3:0] ST_AVG_DIV = 4'd6;
    localparam logic [3:0] ST_OUT     = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                case (status.req_type)
                    fta_pkg::REQ_FRAME: state_next = ST_FRAME;
                    fta_pkg::REQ_STEP:  state_next = ST_STEP;
                    default:            state_next = ST_OUT;
                endcase
            end
            ST_FRAME: begin
                cmd.frame = 1'b1;
                if (status.fps_close) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = fta_pkg::DSEL_FPS;
                    state_next    = ST_FPS_DIV;
                end else if (status.phys_close) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = fta_pkg::DSEL_PHY;
                    state_next    = ST_PHY_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_OUT;
            end
            ST_FPS_DIV: begin
                if (status.div_done) begin
                    cmd.wb     = 1'b1;
                    cmd.wb_sel = fta_pkg::DSEL_FPS;
                    if (status.phys_close) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = fta_pkg::DSEL_PHY;
                        state_next    = ST_PHY_DIV;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PHY_DIV: begin
                if (status.div_done) begin
                    cmd.wb        = 1'b1;
                    cmd.wb_sel    = fta_pkg::DSEL_PHY;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = fta_pkg::DSEL_AVG;
                    state_next    = ST_AVG_DIV;
                end
            end
            ST_AVG_DIV: begin
                if (status.div_done) begin
                    cmd.wb     = 1'b1;
                    cmd.wb_sel = fta_pkg::DSEL_AVG;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== rtl/fixed_timestep_accumulator.sv =====
// Top level of the fixed-timestep accumulator with frame and physics rate meters.
// Depends on fta_pkg, fta_ctrl, fta_datapath (and through it fta_divider).
//
// Usage: each beat on the s_ channel is one request, selected by s_tuser:
// begin frame (adds s_tdata frame duration to the unscaled, scaled and reserve
// totals and to the enabled rate windows), try fixed step (takes one step from
// the reserve and advances the fixed time), or add a physics step cost.
// Every request gives exactly one beat on the m_ channel carrying the current
// totals and rate results. Configuration is written through cfg_we/cfg_index/
// cfg_wdata while the block is idle; writing 1 to an enable clears that window.
//
// Timing: requests are handled one at a time. A cost or unused request passes
// the execute and output states, a try-step or a frame without a window closure
// also its step or frame state. Each closing window adds a wait for a quotient
// from the shared one-bit-per-cycle divider: a frame rate closure one quotient,
// a physics closure two (rate and average).
// The result beat appears in the cycle after the request leaves the pipeline.
//
// Reset (aresetn low, synchronous) restores the configuration defaults and
// clears all totals, counters and results. A stalled receiver holds the result
// in the output register; the next request is still accepted and processed, and
// it waits in its final state only until the held result has been taken.
module fixed_timestep_accumulator #(
    parameter int ACCUM_WIDTH = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fta_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fta_pkg::S_TDATA_W-1:0]  s_tdata,  // frame_dt_us[19:0], step_time_us[39:20]
    input  logic [1:0]                     s_tuser,  // req_type[1:0]

    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // step_taken[0], scaled_delta_us[28:1], unscaled_time_us[76:29],
    // scaled_time_us[132:77], fixed_time_us[188:133], fps_value[220:189],
    // physics_fps_value[252:221], physics_step_avg_us[272:253], zero pad above
    output logic [fta_pkg::M_TDATA_W-1:0]  m_tdata
);

    fta_pkg::fta_cmd_t    cmd;
    fta_pkg::fta_status_t status;

    // The controller owns the handshakes and the sequence of steps.
    fta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds all configuration, accumulators and the result register.
    fta_datapath #(
        .AW (ACCUM_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_req_type (s_tuser),
        .in_data     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_data    (m_tdata)
    );

    // A result is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    // Only one request is in flight: ready drops right after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // A quotient is written back only when the divider has finished.
    a_wb_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |-> status.div_done)
        else $error("quotient written back before the divider finished");

    // A new division is started only in the frame step or on a finished one.
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (cmd.frame || status.div_done))
        else $error("divider restarted while busy");

endmodule

// ===== tb/fta_checker.sv =====
`timescale 1ns / 1ps
// Stream checker for the fixed-timestep accumulator: predicts every result beat
// and compares it field by field. Depends on fta_pkg only.
module fta_checker import fta_pkg::*; #(
    parameter int ACCUM_WIDTH = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    mismatches,
    output int                    outstanding
);

    // Result fields, last field in the lowest bits as on m_tdata.
    typedef struct packed {
        logic [AVG_W-1:0]     step_avg;
        logic [CNT_W-1:0]     phy_rate;
        logic [CNT_W-1:0]     fps_rate;
        logic [TOT_W-1:0]     fixed_t;
        logic [TOT_W-1:0]     scaled_t;
        logic [UNS_OUT_W-1:0] unscaled_t;
        logic [SD_W-1:0]      sdelta;
        logic                 taken;
    } time_report_t;

    localparam logic [63:0] ACC_MAX = (64'd1 << ACCUM_WIDTH) - 64'd1;
    localparam logic [63:0] W56_MAX = (64'd1 << 56) - 64'd1;
    localparam logic [63:0] W48_MAX = (64'd1 << 48) - 64'd1;
    localparam logic [63:0] W32_MAX = 64'hFFFF_FFFF;
    localparam logic [63:0] W20_MAX = 64'hF_FFFF;

    // Configuration copy.
    logic [63:0] scale_q88, step_len, fps_span, phy_span;
    logic        fps_on, phy_on;

    // Timekeeping state.
    logic [63:0] last_sd, unscaled_sum, scaled_sum, reserve, fixed_sum;
    logic [63:0] frames, fps_win, fps_res;
    logic [63:0] steps, phy_win, cost_sum, phy_res, avg_res;

    time_report_t expected_reports[$];
    int           beat_idx;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] lim);
        logic [63:0] x;
        x = (a > lim) ? lim : a;
        return (b > lim - x) ? lim : x + b;
    endfunction

    function automatic logic [63:0] q8_rate(logic [63:0] n, logic [63:0] win);
        logic [63:0] q;
        if (win == 64'd0) return 64'd0;
        q = (n * 64'(RATE_NUM)) / win;
        return (q > W32_MAX) ? W32_MAX : q;
    endfunction

    function automatic void clear_fps_window();
        frames = 0; fps_win = 0; fps_res = 0;
    endfunction

    function automatic void clear_phy_window();
        steps = 0; phy_win = 0; cost_sum = 0; phy_res = 0; avg_res = 0;
    endfunction

    function automatic void reset_timekeeper();
        scale_q88 = 64'(TIME_SCALE_RST);
        step_len  = 64'(FIXED_STEP_RST);
        fps_span  = 64'(FPS_INTERVAL_RST);
        phy_span  = 64'(PHY_INTERVAL_RST);
        fps_on = 1'b0;
        phy_on = 1'b0;
        last_sd = 0; unscaled_sum = 0; scaled_sum = 0; reserve = 0; fixed_sum = 0;
        clear_fps_window();
        clear_phy_window();
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_TIME_SCALE:   scale_q88 = 64'(val[15:0]);
            CFG_FIXED_STEP:   step_len  = 64'(val[19:0]);
            CFG_FPS_INTERVAL: fps_span  = 64'(val);
            CFG_PHY_INTERVAL: phy_span  = 64'(val);
            CFG_FPS_ENABLE: begin
                fps_on = val[0];
                if (val[0]) clear_fps_window();
            end
            CFG_PHY_ENABLE: begin
                phy_on = val[0];
                if (val[0]) clear_phy_window();
            end
            default: ;
        endcase
    endfunction

    // Applies one request to the state and returns the report it produces.
    function automatic time_report_t predict_totals(req_type_t kind, logic [63:0] dt,
                                                    logic [63:0] cost);
        time_report_t rep;
        logic [63:0]  sd, capped;
        logic         taken;
        taken = 1'b0;
        if (kind == REQ_FRAME) begin
            sd = (dt * scale_q88) >> 8;
            last_sd = {36'd0, sd[27:0]};
            unscaled_sum = sat_sum(unscaled_sum, dt, ACC_MAX);
            scaled_sum = sat_sum(scaled_sum, sd, W56_MAX);
            reserve = sat_sum(reserve, dt, ACC_MAX);
            if (fps_on) begin
                frames = sat_sum(frames, 64'd1, W32_MAX);
                fps_win = sat_sum(fps_win, dt, ACC_MAX);
                if (fps_win >= fps_span) begin
                    fps_res = q8_rate(frames, fps_win);
                    frames = 0;
                    fps_win = 0;
                end
            end
            if (phy_on) begin
                phy_win = sat_sum(phy_win, dt, ACC_MAX);
                if (phy_win >= phy_span) begin
                    phy_res = q8_rate(steps, phy_win);
                    if (steps > 0) begin
                        capped = cost_sum / steps;
                        avg_res = (capped > W20_MAX) ? W20_MAX : capped;
                    end else begin
                        avg_res = 0;
                    end
                    steps = 0;
                    phy_win = 0;
                    cost_sum = 0;
                end
            end
        end else if (kind == REQ_STEP) begin
            if (reserve >= step_len) begin
                reserve = reserve - step_len;
                fixed_sum = sat_sum(fixed_sum, (step_len * scale_q88) >> 8, W56_MAX);
                if (phy_on) steps = sat_sum(steps, 64'd1, W32_MAX);
                taken = 1'b1;
            end
        end else if (kind == REQ_COST) begin
            if (phy_on) cost_sum = sat_sum(cost_sum, cost, ACC_MAX);
        end
        capped = (unscaled_sum > W48_MAX) ? W48_MAX : unscaled_sum;
        rep.taken      = taken;
        rep.sdelta     = last_sd[SD_W-1:0];
        rep.unscaled_t = capped[UNS_OUT_W-1:0];
        rep.scaled_t   = scaled_sum[TOT_W-1:0];
        rep.fixed_t    = fixed_sum[TOT_W-1:0];
        rep.fps_rate   = fps_res[CNT_W-1:0];
        rep.phy_rate   = phy_res[CNT_W-1:0];
        rep.step_avg   = avg_res[AVG_W-1:0];
        return rep;
    endfunction

    function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("MISMATCH beat %0d %s: expected 0x%0h, got 0x%0h",
                         beat_idx, fname, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        mismatches = 0;
        outstanding = 0;
        beat_idx = 0;
        reset_timekeeper();
    end

    always @(posedge aclk) begin
        time_report_t want, got;
        if (!aresetn) begin
            reset_timekeeper();
            expected_reports.delete();
        end else begin
            if (cfg_we) write_register(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready)
                expected_reports.push_back(predict_totals(s_tuser, 64'(s_tdata[19:0]),
                                                          64'(s_tdata[39:20])));
            if (m_tvalid && m_tready) begin
                got = m_tdata[M_FIELD_W-1:0];
                if (expected_reports.size() == 0) begin
                    if (mismatches < 10)
                        $display("MISMATCH beat %0d: result with nothing pending", beat_idx);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("step_taken", 64'(want.taken), 64'(got.taken));
                    check_field("scaled_delta_us", 64'(want.sdelta), 64'(got.sdelta));
                    check_field("unscaled_time_us", 64'(want.unscaled_t), 64'(got.unscaled_t));
                    check_field("scaled_time_us", 64'(want.scaled_t), 64'(got.scaled_t));
                    check_field("fixed_time_us", 64'(want.fixed_t), 64'(got.fixed_t));
                    check_field("fps_value", 64'(want.fps_rate), 64'(got.fps_rate));
                    check_field("physics_fps_value", 64'(want.phy_rate), 64'(got.phy_rate));
                    check_field("physics_step_avg_us", 64'(want.step_avg), 64'(got.step_avg));
                    check_field("pad", 64'd0, 64'(m_tdata[M_TDATA_W-1:M_FIELD_W]));
                end
                beat_idx++;
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

// ===== tb/tb_fixed_timestep_accumulator.sv =====
`timescale 1ns / 1ps
// Top of the fixed-timestep accumulator testbench: clock, reset, stimulus and verdict.
// Depends on fta_pkg, fixed_timestep_accumulator and fta_checker.
module tb_fixed_timestep_accumulator;
    import fta_pkg::*;

    // The request type that the block only reports on.
    localparam req_type_t REQ_UNUSED = 2'd3;

    // Even with random gaps on both sides and the long receiver hold, the whole
    // run stays far below this.
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // frame_dt_us[19:0], step_time_us[39:20]
    logic [1:0]            s_tuser;   // req_type[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // result fields, step_taken in bit 0

    int mismatches;
    int outstanding;
    int cycles;

    // Idling controls set by the stimulus for the sender and the receiver process.
    bit tx_idle_en;
    bit rx_idle_en;
    bit long_hold_req;

    fixed_timestep_accumulator #(.ACCUM_WIDTH(48)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fta_checker #(.ACCUM_WIDTH(48)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: if the run has not finished by the limit, something hung.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver. It stalls in random bursts while idling is on, and on request
    // holds off for one long stretch so that the output register and the request
    // behind it both fill and the block stops taking beats.
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one request beat and returns at the edge where it is accepted.
    // With idling on, a random gap may come first. The valid stays high between
    // back-to-back beats, so it is assigned once per step.
    task automatic send_req(input req_type_t kind, input logic [19:0] dt,
                            input logic [19:0] cost);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cost, dt};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every expected result beat has come back.
    // The first edge lets the checker count the beat accepted just before.
    // It then waits on so that the block settles before any register write.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all six registers back to back. Writing 1 to an enable clears
    // that window's counters, writing 0 freezes them.
    task automatic set_config(input logic [23:0] scale, input logic [23:0] step,
                              input logic [23:0] fps_iv, input logic [23:0] phy_iv,
                              input bit fps_en, input bit phy_en);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIME_SCALE;
        cfg_wdata <= scale;
        @(posedge aclk);
        cfg_index <= CFG_FIXED_STEP;
        cfg_wdata <= step;
        @(posedge aclk);
        cfg_index <= CFG_FPS_INTERVAL;
        cfg_wdata <= fps_iv;
        @(posedge aclk);
        cfg_index <= CFG_PHY_INTERVAL;
        cfg_wdata <= phy_iv;
        @(posedge aclk);
        cfg_index <= CFG_FPS_ENABLE;
        cfg_wdata <= {23'd0, fps_en};
        @(posedge aclk);
        cfg_index <= CFG_PHY_ENABLE;
        cfg_wdata <= {23'd0, phy_en};
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random but plausible settings: steps around a typical frame length so the
    // reserve both builds up and runs dry, and windows that close every few
    // frames. The full 24-bit scale write checks that the upper bits are dropped.
    task automatic random_config();
        logic [23:0] scale, step, fps_iv, phy_iv;
        case ($urandom_range(0, 3))
            0: scale = 24'd256;
            1: scale = 24'd65535;
            2: scale = 24'($urandom);
            default: scale = 24'($urandom_range(1, 512));
        endcase
        step   = ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom_range(1, 40000));
        fps_iv = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 1000))
                                             : 24'($urandom_range(1, 1500000));
        phy_iv = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 1000))
                                             : 24'($urandom_range(1, 1500000));
        set_config(scale, step, fps_iv, phy_iv,
                   $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
    endtask

    // Game-loop shaped traffic: a frame, then a few fixed-step attempts, most of
    // them followed by the cost of the step. One item in ten is noise with any
    // request type, the unused one included. Unused fields carry random bits.
    task automatic run_traffic(input int n_items);
        int          sent;
        int          tries;
        logic [19:0] dt;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_req(req_type_t'($urandom_range(0, 3)), 20'($urandom_range(0, 1000000)),
                         20'($urandom_range(0, 1000000)));
                sent++;
            end else begin
                dt = ($urandom_range(0, 7) == 0) ? 20'($urandom_range(0, 1000000))
                                                 : 20'($urandom_range(0, 40000));
                send_req(REQ_FRAME, dt, 20'($urandom_range(0, 1000000)));
                sent++;
                tries = $urandom_range(0, 3);
                repeat (tries) begin
                    send_req(REQ_STEP, 20'($urandom_range(0, 1000000)),
                             20'($urandom_range(0, 1000000)));
                    sent++;
                    if ($urandom_range(0, 2) != 0) begin
                        send_req(REQ_COST, 20'($urandom_range(0, 1000000)),
                                 ($urandom_range(0, 7) == 0) ? 20'($urandom_range(0, 1000000))
                                                             : 20'($urandom_range(0, 30000)));
                        sent++;
                    end
                end
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TIME_SCALE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_FRAME;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        long_hold_req = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, both windows off: the unused request type, a step
        // attempt on an empty reserve, a cost that must be ignored, then the
        // shortest and longest frames and a step that now succeeds.
        send_req(REQ_UNUSED, 20'hFFFFF, 20'hFFFFF);
        send_req(REQ_STEP, 20'd0, 20'd0);
        send_req(REQ_COST, 20'd0, 20'd1000000);
        send_req(REQ_FRAME, 20'd0, 20'd0);
        send_req(REQ_FRAME, 20'd1000000, 20'd0);
        send_req(REQ_STEP, 20'd0, 20'd0);
        drain();

        // Largest scale, zero step length, frame window of zero length and a
        // one-microsecond physics window: every step attempt succeeds without
        // touching the reserve, and a zero-length frame closes at rate 0.
        set_config(24'd65535, 24'd0, 24'd0, 24'd1, 1'b1, 1'b1);
        send_req(REQ_FRAME, 20'd0, 20'd0);
        send_req(REQ_STEP, 20'd0, 20'd0);
        send_req(REQ_COST, 20'd0, 20'd1000000);
        send_req(REQ_COST, 20'd0, 20'd0);
        send_req(REQ_FRAME, 20'd1, 20'd0);
        send_req(REQ_FRAME, 20'd1000000, 20'd0);
        send_req(REQ_UNUSED, 20'd0, 20'd0);
        drain();

        // Zero scale, longest step and longest windows, physics counting off.
        set_config(24'd0, 24'd1000000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_req(REQ_FRAME, 20'd1000000, 20'd0);
        send_req(REQ_STEP, 20'd0, 20'd0);
        send_req(REQ_COST, 20'd0, 20'd500000);
        send_req(REQ_STEP, 20'd0, 20'd0);
        drain();

        // Physics window that closes with no steps in it, so the average is 0;
        // the frame window is frozen with its earlier counts.
        set_config(24'd256, 24'd20000, 24'd1, 24'd1, 1'b0, 1'b1);
        send_req(REQ_FRAME, 20'd5, 20'd0);
        send_req(REQ_STEP, 20'd0, 20'd0);
        send_req(REQ_COST, 20'd0, 20'd77);
        send_req(REQ_FRAME, 20'd3, 20'd0);
        drain();

        // Random phases, each under fresh settings.
        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            run_traffic(50);
            if (phase == 3) begin
                // Long receiver hold while the sender keeps offering back to back.
                tx_idle_en    = 1'b0;
                long_hold_req = 1'b1;
                run_traffic(12);
                tx_idle_en = 1'b1;
            end
            if (phase == 5) begin
                // Sender pause until everything outstanding has come back.
                drain();
                run_traffic(10);
            end
            drain();
        end

        // Last stretch at full rate on both sides.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_config();
        run_traffic(100);
        drain();
        repeat (200) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
